FILE: hdl/compacting_list_store_core_macros.svh
// Assertion macros for the compacting list store RTL.
`ifndef COMPACTING_LIST_STORE_CORE_MACROS_SVH
`define COMPACTING_LIST_STORE_CORE_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define CLSR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property on every clock edge, reset included.
`define CLSR_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define CLSR_ASSERT(name, clk, rst, prop)
`define CLSR_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: hdl/clsr_pkg.sv
// Shared types, constants and elaboration helpers for the compacting list store.
`default_nettype none

package clsr_pkg;

   localparam int OPCODE_BITS   = 2;
   localparam int POSITION_BITS = 6;
   localparam int VALUE_BITS    = 32;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 7;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_ENTRY_BITS = 32;

   // fan-in of each node of the read-out OR tree
   localparam int TREE_FANIN = 8;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_APPEND = 2'd0,
      OP_SET    = 2'd1,
      OP_GET    = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        read_en;
   } clsr_ctl_type;

   // nodes on level lvl of the tree over n leaves (level 0 = leaves)
   function automatic int tree_nodes(int n, int lvl);
      int c;
      c = n;
      for (int k = 0; k < lvl; k++) begin
         c = (c + TREE_FANIN - 1) / TREE_FANIN;
      end
      return c;
   endfunction

   // registered levels until a single root remains
   function automatic int tree_levels(int n);
      int c;
      int lvl;
      c   = n;
      lvl = 0;
      while (c > 1) begin
         c   = (c + TREE_FANIN - 1) / TREE_FANIN;
         lvl = lvl + 1;
      end
      return lvl;
   endfunction

   // first slot of level lvl (lvl >= 1) in the flat node store
   function automatic int tree_offset(int n, int lvl);
      int sum;
      sum = 0;
      for (int k = 1; k < lvl; k++) begin
         sum = sum + tree_nodes(n, k);
      end
      return sum;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/clsr_if.sv
// Request and response channel interfaces of the compacting list store.
`default_nettype none

interface clsr_req_if;
   logic                                valid;
   logic                                ready;
   logic [clsr_pkg::OPCODE_BITS-1:0]    opcode;
   logic [clsr_pkg::POSITION_BITS-1:0]  position;
   logic [clsr_pkg::VALUE_BITS-1:0]     entry_value;

   modport source (output valid, output opcode, output position, output entry_value,
                   input ready);
   modport sink (input valid, input opcode, input position, input entry_value,
                 output ready);
endinterface

interface clsr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [clsr_pkg::STATUS_BITS-1:0]    status;
   logic [clsr_pkg::POSITION_BITS-1:0]  new_index;
   logic [clsr_pkg::VALUE_BITS-1:0]     read_value;
   logic [clsr_pkg::COUNT_BITS-1:0]     entry_count;

   modport source (output valid, output status, output new_index, output read_value,
                   output entry_count, input ready);
   modport sink (input valid, input status, input new_index, input read_value,
                 input entry_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/clsr_cell.sv
// One list slot: holds an entry, takes a write or its upper neighbor's entry.
`default_nettype none

module clsr_cell #(
   parameter int ENTRY_BITS = clsr_pkg::DEF_ENTRY_BITS,
   parameter int IDX_BITS   = 6,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  clsr_pkg::clsr_ctl_type ctl,
   input  logic [IDX_BITS-1:0]    wr_idx,
   input  logic [IDX_BITS-1:0]    rd_idx,
   input  logic [ENTRY_BITS-1:0]  wdata,
   input  logic [ENTRY_BITS-1:0]  next_value,
   output logic [ENTRY_BITS-1:0]  value,
   output logic [ENTRY_BITS-1:0]  read_value
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

   logic [ENTRY_BITS-1:0] value_ff;
   logic [ENTRY_BITS-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         clsr_pkg::CELL_WRITE: begin
            if (wr_idx == MY_IDX) value_in = wdata;
         end
         clsr_pkg::CELL_SHIFT: begin
            // every slot at or above the removed one pulls from above
            if (MY_IDX >= wr_idx) value_in = next_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign read_value = (ctl.read_en && (rd_idx == MY_IDX)) ? value_ff : '0;

endmodule

`default_nettype wire

FILE: hdl/clsr_or_tree.sv
// Registered OR tree that gathers the one selected cell's entry.
`default_nettype none

module clsr_or_tree #(
   parameter int LEAVES = clsr_pkg::DEF_CAPACITY,
   parameter int WIDTH  = clsr_pkg::DEF_ENTRY_BITS
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int FANIN  = clsr_pkg::TREE_FANIN;
   localparam int LEVELS = clsr_pkg::tree_levels(LEAVES);
   localparam int TOTAL  = clsr_pkg::tree_offset(LEAVES, LEVELS + 1);

   logic [WIDTH-1:0] node_ff [TOTAL];
   logic [WIDTH-1:0] node_in [TOTAL];

   for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
      for (genvar nd = 0; nd < clsr_pkg::tree_nodes(LEAVES, lv); nd++) begin : g_node
         localparam int PREV = clsr_pkg::tree_nodes(LEAVES, lv - 1);
         localparam int KIDS = (PREV - nd * FANIN < FANIN) ? PREV - nd * FANIN : FANIN;
         localparam int SELF = clsr_pkg::tree_offset(LEAVES, lv) + nd;
         if (lv == 1) begin : g_leaf
            always_comb begin
               node_in[SELF] = '0;
               for (int j = 0; j < KIDS; j++) begin
                  node_in[SELF] = node_in[SELF] | leaf[nd * FANIN + j];
               end
            end
         end else begin : g_inner
            localparam int BASE = clsr_pkg::tree_offset(LEAVES, lv - 1) + nd * FANIN;
            always_comb begin
               node_in[SELF] = '0;
               for (int j = 0; j < KIDS; j++) begin
                  node_in[SELF] = node_in[SELF] | node_ff[BASE + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < TOTAL; n++) begin
         node_ff[n] <= node_in[n];
      end
   end

   assign root = node_ff[TOTAL-1];

endmodule

`default_nettype wire

FILE: hdl/compacting_list_store_core.sv
// Compacting list store: a row of entry cells with append, set, get and remove.
//
// Requests arrive on req_chan (opcode, position, entry_value) and each one gives
// exactly one response on rsp_chan (status, new_index, read_value, entry_count).
// Append writes at the end, set overwrites, get reads, remove deletes an entry
// and every later cell takes its upper neighbor's entry in the same cycle.
// A request is accepted when req_chan.ready is high; its response is loaded
// into the output register once the read passes the registered levels of
// the read-out OR tree, whose depth LEVELS is ceil(log8(CAPACITY)).
// One request is in flight at a time, so a new request is taken only once
// the previous response has been loaded into the output register.
// Synchronous reset empties the list and clears both handshakes; the entry
// cells are not cleared and hold undefined data until written.
// When the receiver stalls, the response waits in the output register; one
// more request is accepted and completed, then req_chan.ready stays low until
// the waiting response is taken.
`default_nettype none

`include "compacting_list_store_core_macros.svh"

module compacting_list_store_core #(
   parameter int CAPACITY   = clsr_pkg::DEF_CAPACITY,
   parameter int ENTRY_BITS = clsr_pkg::DEF_ENTRY_BITS
) (
   input logic        clock,
   input logic        reset,
   clsr_req_if.sink   req_chan,
   clsr_rsp_if.source rsp_chan
);

   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int CMP_BITS  = (clsr_pkg::POSITION_BITS > CNT_BITS) ?
                              clsr_pkg::POSITION_BITS : CNT_BITS;
   localparam int LEVELS    = clsr_pkg::tree_levels(CAPACITY);
   localparam int WAIT_BITS = $clog2(LEVELS + 1);

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;
   logic                 get_ff, get_in;
   logic [IDX_BITS-1:0]  rd_pos_ff, rd_pos_in;
   logic [clsr_pkg::STATUS_BITS-1:0]   st_ff, st_in;
   logic [clsr_pkg::POSITION_BITS-1:0] idx_ff, idx_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [clsr_pkg::STATUS_BITS-1:0]    rsp_status_ff;
   logic [clsr_pkg::POSITION_BITS-1:0]  rsp_index_ff;
   logic [clsr_pkg::VALUE_BITS-1:0]     rsp_value_ff;
   logic [clsr_pkg::COUNT_BITS-1:0]     rsp_count_ff;

   clsr_pkg::opcode_type   req_op;
   clsr_pkg::cell_op_type  cell_op;
   clsr_pkg::clsr_ctl_type cell_ctl;
   logic                   accept;
   logic                   full;
   logic                   in_range;
   logic                   done;
   logic                   load;
   logic [IDX_BITS-1:0]    wr_idx;
   logic [ENTRY_BITS-1:0]  wdata;
   logic [ENTRY_BITS-1:0]  cell_value [CAPACITY];
   logic [ENTRY_BITS-1:0]  cell_read [CAPACITY];
   logic [ENTRY_BITS-1:0]  tree_root;

   // request decode and list bookkeeping
   always_comb begin
      req_op    = clsr_pkg::opcode_type'(req_chan.opcode);
      full      = (count_ff == CNT_BITS'(CAPACITY));
      in_range  = (CMP_BITS'(req_chan.position) < CMP_BITS'(count_ff));
      accept    = req_chan.valid && !busy_ff && !reset;
      wdata     = ENTRY_BITS'(req_chan.entry_value);
      wr_idx    = IDX_BITS'(req_chan.position);
      cell_op   = clsr_pkg::CELL_HOLD;
      count_in  = count_ff;
      st_in     = st_ff;
      idx_in    = idx_ff;
      get_in    = get_ff;
      rd_pos_in = rd_pos_ff;
      if (accept) begin
         st_in     = clsr_pkg::ST_DONE;
         idx_in    = '0;
         get_in    = 1'b0;
         rd_pos_in = IDX_BITS'(req_chan.position);
         case (req_op)
            clsr_pkg::OP_APPEND: begin
               if (full) begin
                  st_in = clsr_pkg::ST_FULL;
               end else begin
                  cell_op  = clsr_pkg::CELL_WRITE;
                  wr_idx   = count_ff[IDX_BITS-1:0];
                  idx_in   = clsr_pkg::POSITION_BITS'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            clsr_pkg::OP_SET: begin
               if (!in_range) st_in = clsr_pkg::ST_RANGE;
               else cell_op = clsr_pkg::CELL_WRITE;
            end
            clsr_pkg::OP_GET: begin
               if (!in_range) st_in = clsr_pkg::ST_RANGE;
               else get_in = 1'b1;
            end
            clsr_pkg::OP_REMOVE: begin
               if (!in_range) begin
                  st_in = clsr_pkg::ST_RANGE;
               end else begin
                  cell_op  = clsr_pkg::CELL_SHIFT;
                  count_in = count_ff - 1'b1;
               end
            end
            default: st_in = clsr_pkg::ST_RANGE;
         endcase
      end
   end

   always_comb begin
      cell_ctl.op      = cell_op;
      cell_ctl.read_en = get_ff;
   end

   // wait out the read-out tree, then hand over to the output register
   always_comb begin
      done    = busy_ff && (wait_ff == '0);
      load    = done && (!rsp_valid_ff || rsp_chan.ready);
      busy_in = busy_ff;
      wait_in = wait_ff;
      if (accept) begin
         busy_in = 1'b1;
         wait_in = WAIT_BITS'(LEVELS);
      end else if (load) begin
         busy_in = 1'b0;
      end else if (busy_ff && (wait_ff != '0)) begin
         wait_in = wait_ff - 1'b1;
      end
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         wait_ff      <= '0;
         get_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         wait_ff      <= wait_in;
         get_ff       <= get_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff     <= st_in;
      idx_ff    <= idx_in;
      rd_pos_ff <= rd_pos_in;
      if (load) begin
         rsp_status_ff <= st_ff;
         rsp_index_ff  <= idx_ff;
         rsp_value_ff  <= clsr_pkg::VALUE_BITS'(tree_root);
         rsp_count_ff  <= clsr_pkg::COUNT_BITS'(count_ff);
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ENTRY_BITS-1:0] next_value;
      if (k == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[k];
      end else begin : g_mid
         assign next_value = cell_value[k+1];
      end
      clsr_cell #(
         .ENTRY_BITS (ENTRY_BITS),
         .IDX_BITS   (IDX_BITS),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .wr_idx     (wr_idx),
         .rd_idx     (rd_pos_ff),
         .wdata      (wdata),
         .next_value (next_value),
         .value      (cell_value[k]),
         .read_value (cell_read[k])
      );
   end

   clsr_or_tree #(
      .LEAVES (CAPACITY),
      .WIDTH  (ENTRY_BITS)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_read),
      .root  (tree_root)
   );

   assign req_chan.ready       = !busy_ff && !reset;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.new_index   = rsp_index_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   `CLSR_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_BITS'(CAPACITY))
   `CLSR_ASSERT(a_append_grows, clock, reset, (accept && (req_op == clsr_pkg::OP_APPEND) && !full) |=> (count_ff == $past(count_ff) + 1'b1))
   `CLSR_ASSERT(a_remove_shrinks, clock, reset, (accept && (req_op == clsr_pkg::OP_REMOVE) && in_range) |=> (count_ff == $past(count_ff) - 1'b1))
   `CLSR_ASSERT_ALWAYS(a_idle_no_wait, clock, (!busy_ff) |-> (wait_ff == '0))

endmodule

`default_nettype wire
